// ----- hdl/lts_pkg.sv -----
package lts_pkg;

   localparam int OFFSET_BITS = 24;
   localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
   localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;

   localparam logic [5:0] K_SEMI    = 6'd0;
   localparam logic [5:0] K_RARR    = 6'd1;
   localparam logic [5:0] K_MM      = 6'd2;
   localparam logic [5:0] K_MA      = 6'd3;
   localparam logic [5:0] K_MINUS   = 6'd4;
   localparam logic [5:0] K_PP      = 6'd5;
   localparam logic [5:0] K_PA      = 6'd6;
   localparam logic [5:0] K_PLUS    = 6'd7;
   localparam logic [5:0] K_ANDAND  = 6'd8;
   localparam logic [5:0] K_ANDA    = 6'd9;
   localparam logic [5:0] K_AND     = 6'd10;
   localparam logic [5:0] K_OROR    = 6'd11;
   localparam logic [5:0] K_ORA     = 6'd12;
   localparam logic [5:0] K_OR      = 6'd13;
   localparam logic [5:0] K_EXCL    = 6'd14;
   localparam logic [5:0] K_NEQ     = 6'd15;
   localparam logic [5:0] K_PCT     = 6'd16;
   localparam logic [5:0] K_PCTA    = 6'd17;
   localparam logic [5:0] K_STAR    = 6'd18;
   localparam logic [5:0] K_STARA   = 6'd19;
   localparam logic [5:0] K_SLASH   = 6'd20;
   localparam logic [5:0] K_SLASHA  = 6'd21;
   localparam logic [5:0] K_ASSIGN  = 6'd22;
   localparam logic [5:0] K_EQ      = 6'd23;
   localparam logic [5:0] K_HAT     = 6'd24;
   localparam logic [5:0] K_HATA    = 6'd25;
   localparam logic [5:0] K_TILDE   = 6'd26;
   localparam logic [5:0] K_TILDEA  = 6'd27;
   localparam logic [5:0] K_LEQ     = 6'd28;
   localparam logic [5:0] K_SHLA    = 6'd29;
   localparam logic [5:0] K_SHL     = 6'd30;
   localparam logic [5:0] K_LT      = 6'd31;
   localparam logic [5:0] K_GEQ     = 6'd32;
   localparam logic [5:0] K_SHRA    = 6'd33;
   localparam logic [5:0] K_SHR     = 6'd34;
   localparam logic [5:0] K_GT      = 6'd35;
   localparam logic [5:0] K_LPAREN  = 6'd36;
   localparam logic [5:0] K_RPAREN  = 6'd37;
   localparam logic [5:0] K_LBRACE  = 6'd38;
   localparam logic [5:0] K_RBRACE  = 6'd39;
   localparam logic [5:0] K_LBRACK  = 6'd40;
   localparam logic [5:0] K_RBRACK  = 6'd41;
   localparam logic [5:0] K_COMMA   = 6'd42;
   localparam logic [5:0] K_COMMENT = 6'd43;
   localparam logic [5:0] K_INT     = 6'd44;
   localparam logic [5:0] K_NAME    = 6'd45;
   localparam logic [5:0] K_END     = 6'd46;
   localparam logic [5:0] K_INVALID = 6'd47;
   localparam logic [5:0] K_NONE    = 6'd63;

   typedef enum logic [2:0] {
      M_IDLE    = 3'd0,
      M_NAME    = 3'd1,
      M_NUM     = 3'd2,
      M_COMMENT = 3'd3,
      M_OP      = 3'd4
   } mode_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [23:0] start;
      logic [23:0] length;
      logic [31:0] hash;
      logic [23:0] line;
   } token_type;

   // up to three tokens per item, packed in order
   typedef struct packed {
      logic [1:0] count;
      token_type  t0;
      token_type  t1;
      token_type  t2;
   } burst_type;

endpackage

// ----- hdl/lts_core.sv -----
module lts_core
   import lts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       cmd,
   input  logic [7:0] byte_value,
   input  logic       emit_comments,
   output burst_type  burst
);

   localparam logic [OFFSET_BITS-1:0] SAT = {OFFSET_BITS{1'b1}};

   mode_type               mode_ff, mode_in;
   logic [5:0]             pkind_ff, pkind_in;
   logic [OFFSET_BITS-1:0] pstart_ff, pstart_in;
   logic [OFFSET_BITS-1:0] plen_ff, plen_in;
   logic [31:0]            hash_ff, hash_in;
   logic                   semi_ff, semi_in;
   logic [OFFSET_BITS-1:0] ofs_ff, ofs_in;
   logic [OFFSET_BITS-1:0] line_ff, line_in;

   function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
      return (v != SAT) ? v + 1'b1 : SAT;
   endfunction

   function automatic logic [23:0] to24(input logic [OFFSET_BITS-1:0] v);
      logic [OFFSET_BITS+23:0] w;
      w = {24'd0, v};
      return w[23:0];
   endfunction

   function automatic logic sets_semi(input logic [5:0] k);
      return k == K_INT || k == K_NAME || k == K_RPAREN || k == K_RBRACE ||
             k == K_RBRACK || k == K_PP || k == K_MM;
   endfunction

   function automatic logic [5:0] op_start(input logic [7:0] b);
      case (b)
         8'h2D: return K_MINUS;
         8'h2B: return K_PLUS;
         8'h26: return K_AND;
         8'h7C: return K_OR;
         8'h21: return K_EXCL;
         8'h25: return K_PCT;
         8'h2A: return K_STAR;
         8'h2F: return K_SLASH;
         8'h3D: return K_ASSIGN;
         8'h5E: return K_HAT;
         8'h7E: return K_TILDE;
         8'h3C: return K_LT;
         8'h3E: return K_GT;
         default: return K_NONE;
      endcase
   endfunction

   function automatic logic [5:0] single_kind(input logic [7:0] b);
      case (b)
         8'h28: return K_LPAREN;
         8'h29: return K_RPAREN;
         8'h7B: return K_LBRACE;
         8'h7D: return K_RBRACE;
         8'h5B: return K_LBRACK;
         8'h5D: return K_RBRACK;
         8'h2C: return K_COMMA;
         8'h3B: return K_SEMI;
         default: return K_NONE;
      endcase
   endfunction

   function automatic logic [5:0] op_extend(input logic [5:0] k, input logic [7:0] b);
      logic eq;
      eq = (b == 8'h3D);
      case (k)
         K_MINUS: return (b == 8'h3E) ? K_RARR : (b == 8'h2D) ? K_MM : eq ? K_MA : K_NONE;
         K_PLUS:  return (b == 8'h2B) ? K_PP : eq ? K_PA : K_NONE;
         K_AND:   return (b == 8'h26) ? K_ANDAND : eq ? K_ANDA : K_NONE;
         K_OR:    return (b == 8'h7C) ? K_OROR : eq ? K_ORA : K_NONE;
         K_LT:    return (b == 8'h3C) ? K_SHL : eq ? K_LEQ : K_NONE;
         K_GT:    return (b == 8'h3E) ? K_SHR : eq ? K_GEQ : K_NONE;
         K_EXCL:  return eq ? K_NEQ : K_NONE;
         K_PCT:   return eq ? K_PCTA : K_NONE;
         K_STAR:  return eq ? K_STARA : K_NONE;
         K_SLASH: return eq ? K_SLASHA : K_NONE;
         K_ASSIGN: return eq ? K_EQ : K_NONE;
         K_HAT:   return eq ? K_HATA : K_NONE;
         K_TILDE: return eq ? K_TILDEA : K_NONE;
         K_SHL:   return eq ? K_SHLA : K_NONE;
         K_SHR:   return eq ? K_SHRA : K_NONE;
         default: return K_NONE;
      endcase
   endfunction

   always_comb begin
      token_type tk;
      logic [1:0] n;
      logic       finish, is_digit, is_alpha, cont;
      logic [5:0] nk, ok, sk;
      logic [7:0] b;
      token_type  q [3];
      logic [31:0] hx;

      mode_in = mode_ff;
      pkind_in = pkind_ff;
      pstart_in = pstart_ff;
      plen_in = plen_ff;
      hash_in = hash_ff;
      semi_in = semi_ff;
      ofs_in = ofs_ff;
      line_in = line_ff;
      n = 2'd0;
      q[0] = '0;
      q[1] = '0;
      q[2] = '0;
      tk = '0;
      tk.line = to24(line_ff);
      b = byte_value;
      is_digit = b >= 8'h30 && b <= 8'h39;
      is_alpha = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
      cont = is_alpha || is_digit || b == 8'h5F || b == 8'h2B || b == 8'h2D ||
             b == 8'h2E || b[7];
      nk = op_extend(pkind_ff, b);
      ok = op_start(b);
      sk = single_kind(b);
      hx = hash_ff ^ {24'd0, b};
      finish = 1'b0;

      // decide whether the pending token ends at this item
      if (cmd) begin
         finish = 1'b1;
      end else begin
         case (mode_ff)
            M_NAME: begin
               if (cont) begin
                  hash_in = hx * FNV_PRIME;
                  plen_in = sat_inc(plen_ff);
               end else finish = 1'b1;
            end
            M_NUM: begin
               if (is_digit) plen_in = sat_inc(plen_ff);
               else finish = 1'b1;
            end
            M_COMMENT: begin
               if (b != 8'h0A) plen_in = sat_inc(plen_ff);
               else finish = 1'b1;
            end
            M_OP: begin
               if (nk != K_NONE) begin
                  pkind_in = nk;
                  plen_in = sat_inc(plen_ff);
                  if (nk != K_SHL && nk != K_SHR) begin
                     tk.kind = nk;
                     tk.start = to24(pstart_ff);
                     tk.length = to24(sat_inc(plen_ff));
                     q[0] = tk;
                     n = 2'd1;
                     semi_in = sets_semi(nk);
                     mode_in = M_IDLE;
                     pkind_in = K_NONE;
                     plen_in = '0;
                     hash_in = FNV_BASIS;
                  end
               end else finish = 1'b1;
            end
            default: finish = 1'b1;
         endcase
      end

      if (finish) begin
         tk.start = to24(pstart_ff);
         tk.length = to24(plen_ff);
         tk.hash = '0;
         case (mode_ff)
            M_NAME: begin
               tk.kind = K_NAME; tk.hash = hash_ff;
               q[0] = tk; n = 2'd1; semi_in = 1'b1;
            end
            M_NUM: begin
               tk.kind = K_INT; q[0] = tk; n = 2'd1; semi_in = 1'b1;
            end
            M_OP: begin
               tk.kind = pkind_ff; q[0] = tk; n = 2'd1; semi_in = sets_semi(pkind_ff);
            end
            M_COMMENT: begin
               if (emit_comments) begin
                  tk.kind = K_COMMENT; q[0] = tk; n = 2'd1;
               end
            end
            default: ;
         endcase
         mode_in = M_IDLE;
         pkind_in = K_NONE;
         plen_in = '0;
         hash_in = FNV_BASIS;
         tk.start = to24(ofs_ff);
         tk.length = '0;
         tk.hash = '0;
         if (cmd) begin
            if (semi_in) begin
               tk.kind = K_SEMI; q[n] = tk; n = n + 2'd1;
            end
            tk.kind = K_END; q[n] = tk; n = n + 2'd1;
            pstart_in = '0;
            semi_in = 1'b0;
            ofs_in = '0;
            line_in = '0;
         end else begin
            if (b == 8'h0A) begin
               if (semi_in) begin
                  tk.kind = K_SEMI; q[n] = tk; n = n + 2'd1;
                  semi_in = 1'b0;
               end
               line_in = sat_inc(line_ff);
            end else if (b == 8'h09 || b == 8'h0D || b == 8'h20) begin
            end else if (b == 8'h23) begin
               mode_in = M_COMMENT;
               pstart_in = ofs_ff + 1'b1;
            end else if (is_digit) begin
               mode_in = M_NUM; pstart_in = ofs_ff; plen_in = OFFSET_BITS'(1);
            end else if (b == 8'h24 || b == 8'h5F || is_alpha || b[7]) begin
               mode_in = M_NAME; pstart_in = ofs_ff; plen_in = OFFSET_BITS'(1);
               hash_in = (FNV_BASIS ^ {24'd0, b}) * FNV_PRIME;
            end else if (ok != K_NONE) begin
               mode_in = M_OP; pkind_in = ok; pstart_in = ofs_ff; plen_in = OFFSET_BITS'(1);
            end else if (sk != K_NONE) begin
               tk.kind = sk; tk.length = 24'd1; q[n] = tk; n = n + 2'd1;
               semi_in = sets_semi(sk);
            end else begin
               tk.kind = K_INVALID; q[n] = tk; n = n + 2'd1;
               semi_in = 1'b0;
            end
            ofs_in = ofs_ff + 1'b1;
         end
      end else begin
         ofs_in = ofs_ff + 1'b1;
      end

      burst.count = n;
      burst.t0 = q[0];
      burst.t1 = q[1];
      burst.t2 = q[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         pkind_ff <= K_NONE;
         pstart_ff <= '0;
         plen_ff <= '0;
         hash_ff <= FNV_BASIS;
         semi_ff <= 1'b0;
         ofs_ff <= '0;
         line_ff <= '0;
      end else if (step) begin
         mode_ff <= mode_in;
         pkind_ff <= pkind_in;
         pstart_ff <= pstart_in;
         plen_ff <= plen_in;
         hash_ff <= hash_in;
         semi_ff <= semi_in;
         ofs_ff <= ofs_in;
         line_ff <= line_in;
      end
   end

endmodule

// ----- hdl/lts_out.sv -----
module lts_out
   import lts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  burst_type    burst,
   output logic         busy,
   input  logic         rsp_tready,
   output logic         rsp_tvalid,
   output logic         rsp_tlast,
   output logic [111:0] rsp_tdata
);

   logic [1:0] cnt_ff, cnt_in;
   token_type  slot_ff [3];
   token_type  head;

   assign head = slot_ff[0];
   assign rsp_tvalid = cnt_ff != 2'd0;
   assign rsp_tlast = cnt_ff == 2'd1;
   assign rsp_tdata = {2'b00, head.line, head.hash, head.length, head.start, head.kind};
   // free once the last token of the run is leaving
   assign busy = cnt_ff > 2'd1 || (cnt_ff == 2'd1 && !rsp_tready);

   always_comb begin
      cnt_in = cnt_ff;
      if (load) cnt_in = burst.count;
      else if (rsp_tvalid && rsp_tready) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= 2'd0;
      else cnt_ff <= cnt_in;
      if (load) begin
         slot_ff[0] <= burst.t0;
         slot_ff[1] <= burst.t1;
         slot_ff[2] <= burst.t2;
      end else if (rsp_tvalid && rsp_tready) begin
         slot_ff[0] <= slot_ff[1];
         slot_ff[1] <= slot_ff[2];
      end
   end

endmodule

// ----- hdl/lexer_token_scanner_unit.sv -----
// Lexical scanner with semicolon insertion.
// req_*: one item per source byte (tuser=0, tdata=byte) or end of input
// (tuser=1). csr_we/csr_wdata set the comment-emit flag; write only when idle.
// rsp_*: token items; tlast marks the final token caused by one input item.
// Each input item is scanned combinationally; its zero to three tokens are
// loaded into a three-entry output queue and the first one is valid in the
// cycle after acceptance. With a ready receiver the queue drains one token
// per cycle and a byte that makes one token or none sustains one item per
// cycle. req_tready drops only while the queue holds more than the token
// now leaving, so a stalled receiver holds tokens in place and stalls input.
// Reset (synchronous) returns to offset 0, line 0, no pending token and
// comments disabled. End of input also restores the scan state.
module lexer_token_scanner_unit
   import lts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic         csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,  // byte_value
   input  logic         req_tuser,  // cmd
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic         rsp_tlast,  // last_of_run
   output logic [111:0] rsp_tdata   // token_kind, token_start, token_length,
                                    // name_hash, line_number, 2 zero bits
);

   logic      emit_ff;
   logic      busy, step;
   burst_type burst;

   assign req_tready = !busy;
   assign step = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) emit_ff <= 1'b0;
      else if (csr_we) emit_ff <= csr_wdata;
   end

   lts_core u_core (
      .clock(clock), .reset(reset), .step(step), .cmd(req_tuser),
      .byte_value(req_tdata), .emit_comments(emit_ff), .burst(burst)
   );

   lts_out u_out (
      .clock(clock), .reset(reset), .load(step), .burst(burst), .busy(busy),
      .rsp_tready(rsp_tready), .rsp_tvalid(rsp_tvalid), .rsp_tlast(rsp_tlast),
      .rsp_tdata(rsp_tdata)
   );

   a_end_tok: assert property (@(posedge clock) disable iff (reset)
      step && req_tuser |=> rsp_tvalid)
      else $error("end of input gave no token");

   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted while output stalled");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import lts_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_we = 1'b0;
   logic         csr_wdata = 1'b0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'd0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic         rsp_tlast;
   logic [111:0] rsp_tdata;

   typedef struct {
      logic [5:0]  kind;
      logic [23:0] start;
      logic [23:0] length;
      logic [31:0] hash;
      logic [23:0] line;
      logic        last;
   } tok_type;

   typedef struct {
      logic        eoi;
      logic [7:0]  b;
      logic        chk;   // typed expectation follows
      logic [5:0]  kind;
      logic [23:0] start;
   } row_type;

   lexer_token_scanner_unit i_dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tlast(rsp_tlast), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // scanner model state
   logic        m_comments;
   logic [5:0]  m_pkind;
   logic [23:0] m_pstart, m_plen, m_ofs, m_line;
   logic [31:0] m_hash;
   logic        m_semi;
   mode_type    m_mode;

   tok_type expected_tokens[$];
   tok_type burst[$];
   int   errors = 0;
   int   n_items = 0;
   int   n_tokens = 0;
   int   n_eoi = 0;
   bit   hold_long = 0;
   int   idle_cycles = 0;

   function automatic logic [23:0] sat1(logic [23:0] v);
      return (v == 24'hFFFFFF) ? v : v + 24'd1;
   endfunction

   function automatic void emit(logic [5:0] k, logic [23:0] s, logic [23:0] l,
                                logic [31:0] h);
      tok_type t;
      t.kind = k; t.start = s; t.length = l; t.hash = h; t.line = m_line;
      t.last = 1'b0;
      if (burst.size() < 3) burst.push_back(t);
   endfunction

   function automatic void emit_tok(logic [5:0] k, logic [23:0] s, logic [23:0] l,
                                    logic [31:0] h);
      emit(k, s, l, h);
      m_semi = (k == K_INT || k == K_NAME || k == K_RPAREN || k == K_RBRACE ||
                k == K_RBRACK || k == K_PP || k == K_MM);
   endfunction

   function automatic bit ident_cont(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
             (b >= "0" && b <= "9") || b == "_" || b == "+" || b == "-" ||
             b == "." || b >= 8'h80;
   endfunction

   function automatic void close_token();
      case (m_mode)
         M_NAME:    emit_tok(K_NAME, m_pstart, m_plen, m_hash);
         M_NUM:     emit_tok(K_INT, m_pstart, m_plen, 32'd0);
         M_OP:      emit_tok(m_pkind, m_pstart, m_plen, 32'd0);
         M_COMMENT: if (m_comments) emit(K_COMMENT, m_pstart, m_plen, 32'd0);
         default: ;
      endcase
      m_mode = M_IDLE; m_pkind = K_NONE; m_plen = 24'd0; m_hash = FNV_BASIS;
   endfunction

   function automatic logic [5:0] grow_op(logic [5:0] k, logic [7:0] b);
      case (k)
         K_MINUS: return b == ">" ? K_RARR : b == "-" ? K_MM : b == "=" ? K_MA : K_NONE;
         K_PLUS:  return b == "+" ? K_PP : b == "=" ? K_PA : K_NONE;
         K_AND:   return b == "&" ? K_ANDAND : b == "=" ? K_ANDA : K_NONE;
         K_OR:    return b == "|" ? K_OROR : b == "=" ? K_ORA : K_NONE;
         K_LT:    return b == "<" ? K_SHL : b == "=" ? K_LEQ : K_NONE;
         K_GT:    return b == ">" ? K_SHR : b == "=" ? K_GEQ : K_NONE;
         default: ;
      endcase
      if (b != "=") return K_NONE;
      case (k)
         K_EXCL: return K_NEQ;     K_PCT: return K_PCTA;
         K_STAR: return K_STARA;   K_SLASH: return K_SLASHA;
         K_ASSIGN: return K_EQ;    K_HAT: return K_HATA;
         K_TILDE: return K_TILDEA; K_SHL: return K_SHLA;
         K_SHR: return K_SHRA;
         default: return K_NONE;
      endcase
   endfunction

   function automatic logic [5:0] op_first(logic [7:0] b);
      case (b)
         "-": return K_MINUS;  "+": return K_PLUS;  "&": return K_AND;
         "|": return K_OR;     "!": return K_EXCL;  "%": return K_PCT;
         "*": return K_STAR;   "/": return K_SLASH; "=": return K_ASSIGN;
         "^": return K_HAT;    "~": return K_TILDE; "<": return K_LT;
         ">": return K_GT;
         default: return K_NONE;
      endcase
   endfunction

   function automatic logic [5:0] punct_kind(logic [7:0] b);
      case (b)
         "(": return K_LPAREN; ")": return K_RPAREN; "{": return K_LBRACE;
         "}": return K_RBRACE; "[": return K_LBRACK; "]": return K_RBRACK;
         ",": return K_COMMA;  ";": return K_SEMI;
         default: return K_NONE;
      endcase
   endfunction

   function automatic void start_byte(logic [7:0] b);
      logic [5:0] k;
      if (b == 8'h0A) begin
         if (m_semi) begin
            emit(K_SEMI, m_ofs, 24'd0, 32'd0);
            m_semi = 1'b0;
         end
         m_line = sat1(m_line);
         return;
      end
      if (b == 8'h09 || b == 8'h0D || b == " ") return;
      if (b == "#") begin
         m_mode = M_COMMENT; m_pstart = m_ofs + 24'd1; m_plen = 24'd0;
         return;
      end
      if (b >= "0" && b <= "9") begin
         m_mode = M_NUM; m_pstart = m_ofs; m_plen = 24'd1;
         return;
      end
      if (b == "$" || b == "_" || (b >= "a" && b <= "z") ||
          (b >= "A" && b <= "Z") || b >= 8'h80) begin
         m_mode = M_NAME; m_pstart = m_ofs; m_plen = 24'd1;
         m_hash = (FNV_BASIS ^ {24'd0, b}) * FNV_PRIME;
         return;
      end
      k = op_first(b);
      if (k != K_NONE) begin
         m_mode = M_OP; m_pkind = k; m_pstart = m_ofs; m_plen = 24'd1;
         return;
      end
      k = punct_kind(b);
      if (k != K_NONE) begin
         emit_tok(k, m_ofs, 24'd1, 32'd0);
         return;
      end
      emit(K_INVALID, m_ofs, 24'd0, 32'd0);
      m_semi = 1'b0;
   endfunction

   function automatic void scan_reset();
      m_pkind = K_NONE; m_pstart = 0; m_plen = 0; m_hash = FNV_BASIS;
      m_semi = 0; m_mode = M_IDLE; m_ofs = 0; m_line = 0;
   endfunction

   // work out the tokens one input item causes and queue them
   function automatic void predict_tokens(logic eoi, logic [7:0] b);
      logic [5:0] nk;
      bit done;
      burst.delete();
      if (eoi) begin
         close_token();
         if (m_semi) emit(K_SEMI, m_ofs, 24'd0, 32'd0);
         emit(K_END, m_ofs, 24'd0, 32'd0);
         scan_reset();
      end else begin
         done = 0;
         case (m_mode)
            M_NAME: if (ident_cont(b)) begin
               m_hash = (m_hash ^ {24'd0, b}) * FNV_PRIME;
               m_plen = sat1(m_plen); done = 1;
            end
            M_NUM: if (b >= "0" && b <= "9") begin
               m_plen = sat1(m_plen); done = 1;
            end
            M_COMMENT: if (b != 8'h0A) begin
               m_plen = sat1(m_plen); done = 1;
            end
            M_OP: begin
               nk = grow_op(m_pkind, b);
               if (nk != K_NONE) begin
                  m_pkind = nk; m_plen = sat1(m_plen);
                  if (nk != K_SHL && nk != K_SHR) close_token();
                  done = 1;
               end
            end
            default: ;
         endcase
         if (!done) begin
            close_token();
            start_byte(b);
         end
         m_ofs = m_ofs + 24'd1;
      end
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[i]) expected_tokens.push_back(burst[i]);
   endfunction

   // output side: compare each token with the oldest expectation
   always @(posedge clock) begin
      tok_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_tokens++;
         if (expected_tokens.size() == 0) begin
            errors++;
            $display("%0t: unexpected token %h last %b", $time, rsp_tdata, rsp_tlast);
         end else begin
            e = expected_tokens.pop_front();
            if (rsp_tdata[5:0] !== e.kind || rsp_tdata[29:6] !== e.start ||
                rsp_tdata[53:30] !== e.length || rsp_tdata[85:54] !== e.hash ||
                rsp_tdata[109:86] !== e.line || rsp_tlast !== e.last) begin
               errors++;
               $display("%0t: expected kind %0d start %0d len %0d hash %h line %0d last %b",
                        $time, e.kind, e.start, e.length, e.hash, e.line, e.last);
               $display("%0t: actual   kind %0d start %0d len %0d hash %h line %0d last %b",
                        $time, rsp_tdata[5:0], rsp_tdata[29:6], rsp_tdata[53:30],
                        rsp_tdata[85:54], rsp_tdata[109:86], rsp_tlast);
            end
         end
      end
   end

   // receiver stall pattern, plus one long hold-off on request
   initial begin
      int ph;
      ph = 0;
      forever begin
         @(posedge clock);
         ph++;
         if (hold_long) begin
            rsp_tready <= 1'b0;
            repeat (60) @(posedge clock);
            hold_long = 0;
         end
         if ((ph / 40) % 3 == 2) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 2000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   int burst_left = 0;

   task automatic send_item(logic eoi, logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 4);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tuser <= eoi;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_tokens(eoi, b);
      n_items++;
      if (eoi) n_eoi++;
      burst_left--;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_comments(logic v);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      m_comments = v;
   endtask

   function automatic logic [7:0] pick_byte();
      string alpha = "abzAZ_$09+-.=<>!&|%*/^~(){}[],;# \t\r\n";
      case ($urandom_range(0, 9))
         0: return 8'($urandom_range(0, 255));
         1: return 8'($urandom_range(128, 255));
         2: return 8'h0A;
         default: return alpha[$urandom_range(0, alpha.len() - 1)];
      endcase
   endfunction

   row_type dir[$];

   function automatic void add(string s);
      row_type r;
      foreach (s[i]) begin
         r.eoi = 0; r.b = s[i]; r.chk = 0; r.kind = 0; r.start = 0;
         dir.push_back(r);
      end
   endfunction

   initial begin
      row_type r;
      int len;
      scan_reset();
      m_comments = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: invalid byte at offset 0, then a short mixed stream
      r.eoi = 0; r.b = 8'h00; r.chk = 1; r.kind = K_INVALID; r.start = 0;
      dir.push_back(r);
      add("a>=b<<=c\n#x\n");
      r.eoi = 0; r.b = 8'hFF; r.chk = 0; dir.push_back(r);
      add("9)");
      r.eoi = 1; r.b = 8'h00; r.chk = 0; dir.push_back(r);
      r.eoi = 1; r.chk = 1; r.kind = K_END; r.start = 0; dir.push_back(r);
      foreach (dir[i]) begin
         send_item(dir[i].eoi, dir[i].b);
         if (dir[i].chk && (burst.size() == 0 || burst[0].kind != dir[i].kind ||
                            burst[0].start != dir[i].start)) begin
            errors++;
            $display("%0t: table row %0d expected kind %0d start %0d", $time, i,
                     dir[i].kind, dir[i].start);
         end
      end

      set_comments(1'b1);
      add("#note\n++x\n--\n>>=x>>y->z");
      foreach (dir[i]) if (i >= 18) send_item(dir[i].eoi, dir[i].b);
      send_item(1'b1, 8'h00);

      // random streams; full hold-off part way through
      for (int ph = 0; ph < 4; ph++) begin
         set_comments(ph[0]);
         for (int n = 0; n < 50; n++) begin
            if (n == 30 && ph == 1) hold_long = 1;
            len = $urandom_range(0, 9);
            send_item(($urandom_range(0, 24) == 0), pick_byte());
            if (len == 0) send_item(1'b0, 8'h0A);
         end
         send_item(1'b1, 8'($urandom_range(0, 255)));
      end

      wait_drained();
      repeat (20) @(posedge clock);
      $display("Sent %0d items (%0d end-of-input), checked %0d tokens,", n_items,
               n_eoi, n_tokens);
      $display("comment emit flag toggled between both values.");
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
